/* rtl/mexalu_pkg.sv */
// shared opcodes, function codes and types for the execute-stage alu
package mexalu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ImmW  = 16;
  localparam int unsigned OpW   = 6;
  localparam int unsigned ShW   = 5;

  // primary opcodes
  localparam logic [OpW-1:0] OP_RTYPE = 6'd0;
  localparam logic [OpW-1:0] OP_JAL   = 6'd3;
  localparam logic [OpW-1:0] OP_BEQ   = 6'd4;
  localparam logic [OpW-1:0] OP_BNE   = 6'd5;
  localparam logic [OpW-1:0] OP_BGTZ  = 6'd7;
  localparam logic [OpW-1:0] OP_ADDI  = 6'd8;
  localparam logic [OpW-1:0] OP_ADDIU = 6'd9;
  localparam logic [OpW-1:0] OP_SLTI  = 6'd10;
  localparam logic [OpW-1:0] OP_ANDI  = 6'd12;
  localparam logic [OpW-1:0] OP_ORI   = 6'd13;
  localparam logic [OpW-1:0] OP_NORI  = 6'd14;
  localparam logic [OpW-1:0] OP_LUI   = 6'd15;
  localparam logic [OpW-1:0] OP_LB    = 6'd32;
  localparam logic [OpW-1:0] OP_LH    = 6'd33;
  localparam logic [OpW-1:0] OP_LW    = 6'd35;
  localparam logic [OpW-1:0] OP_LBU   = 6'd36;
  localparam logic [OpW-1:0] OP_LHU   = 6'd37;
  localparam logic [OpW-1:0] OP_SB    = 6'd40;
  localparam logic [OpW-1:0] OP_SH    = 6'd41;
  localparam logic [OpW-1:0] OP_SW    = 6'd43;

  // r-type function codes
  localparam logic [OpW-1:0] FN_SLL   = 6'd0;
  localparam logic [OpW-1:0] FN_SRL   = 6'd2;
  localparam logic [OpW-1:0] FN_SRA   = 6'd3;
  localparam logic [OpW-1:0] FN_MFHI  = 6'd16;
  localparam logic [OpW-1:0] FN_MFLO  = 6'd18;
  localparam logic [OpW-1:0] FN_MULT  = 6'd24;
  localparam logic [OpW-1:0] FN_MULTU = 6'd25;
  localparam logic [OpW-1:0] FN_ADD   = 6'd32;
  localparam logic [OpW-1:0] FN_ADDU  = 6'd33;
  localparam logic [OpW-1:0] FN_SUB   = 6'd34;
  localparam logic [OpW-1:0] FN_AND   = 6'd36;
  localparam logic [OpW-1:0] FN_OR    = 6'd37;
  localparam logic [OpW-1:0] FN_XOR   = 6'd38;
  localparam logic [OpW-1:0] FN_NOR   = 6'd39;
  localparam logic [OpW-1:0] FN_NAND  = 6'd40;
  localparam logic [OpW-1:0] FN_SLT   = 6'd42;

  // command from the alu decode to the hi/lo unit
  typedef struct packed {
    logic mult;
    logic mult_signed;
    logic read;
  } hilo_cmd_t;

  // hi/lo unit state seen by the alu
  typedef struct packed {
    logic [DataW-1:0] hi;
    logic [DataW-1:0] lo;
    logic             unread;
  } hilo_state_t;

endpackage

/* rtl/mexalu_alu.sv */
// decode and combinational alu for one instruction
module mexalu_alu (
  input  logic                         bubble,
  input  logic [mexalu_pkg::OpW-1:0]   opcode,
  input  logic [mexalu_pkg::OpW-1:0]   func,
  input  logic [mexalu_pkg::ShW-1:0]   shamt,
  input  logic [mexalu_pkg::ImmW-1:0]  imm,
  input  logic [mexalu_pkg::DataW-1:0] rs_value,
  input  logic [mexalu_pkg::DataW-1:0] rt_value,
  input  logic [mexalu_pkg::DataW-1:0] pc_value,
  input  logic [mexalu_pkg::DataW-1:0] link_value,
  input  logic [mexalu_pkg::DataW-1:0] last_result,
  input  mexalu_pkg::hilo_state_t      hilo,
  output logic [mexalu_pkg::DataW-1:0] result,
  output logic                         num_overflow,
  output logic                         hilo_overwrite,
  output mexalu_pkg::hilo_cmd_t        cmd
);
  import mexalu_pkg::*;

  logic [DataW-1:0] se;
  logic [DataW-1:0] ze;
  logic [DataW-1:0] sum_rr;
  logic [DataW-1:0] diff_rr;
  logic [DataW-1:0] sum_ri;
  logic [DataW-1:0] sum_pc;
  logic             ovf_add_rr;
  logic             ovf_sub_rr;
  logic             ovf_add_ri;
  logic             ovf_pc;
  logic             is_mem;
  logic             is_branch;

  assign se = {{(DataW-ImmW){imm[ImmW-1]}}, imm};
  assign ze = {{(DataW-ImmW){1'b0}}, imm};

  assign sum_rr  = rs_value + rt_value;
  assign diff_rr = rs_value - rt_value;
  assign sum_ri  = rs_value + se;
  assign sum_pc  = pc_value + se;

  assign ovf_add_rr = (rs_value[DataW-1] ^ sum_rr[DataW-1]) &
                      (rt_value[DataW-1] ^ sum_rr[DataW-1]);
  assign ovf_sub_rr = (rs_value[DataW-1] ^ rt_value[DataW-1]) &
                      (rs_value[DataW-1] ^ diff_rr[DataW-1]);
  assign ovf_add_ri = (rs_value[DataW-1] ^ sum_ri[DataW-1]) &
                      (se[DataW-1] ^ sum_ri[DataW-1]);
  assign ovf_pc     = (pc_value[DataW-1] ^ sum_pc[DataW-1]) &
                      (se[DataW-1] ^ sum_pc[DataW-1]);

  // addi and the load/store address adds share the checked add
  assign is_mem = opcode inside {OP_ADDI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
                                 OP_SB, OP_SH, OP_SW};
  assign is_branch = opcode inside {OP_BEQ, OP_BNE, OP_BGTZ};

  always_comb begin
    result         = last_result;
    num_overflow   = 1'b0;
    hilo_overwrite = 1'b0;
    cmd            = '0;
    if (!bubble) begin
      if (opcode == OP_RTYPE) begin
        case (func)
          FN_ADD: begin
            result       = sum_rr;
            num_overflow = ovf_add_rr;
          end
          FN_ADDU: result = sum_rr;
          FN_SUB: begin
            result       = diff_rr;
            num_overflow = ovf_sub_rr;
          end
          FN_AND:  result = rs_value & rt_value;
          FN_OR:   result = rs_value | rt_value;
          FN_XOR:  result = rs_value ^ rt_value;
          FN_NOR:  result = ~(rs_value | rt_value);
          FN_NAND: result = ~(rs_value & rt_value);
          FN_SLT:  result = {{(DataW-1){1'b0}}, $signed(rs_value) < $signed(rt_value)};
          FN_SLL:  result = rt_value << shamt;
          FN_SRL:  result = rt_value >> shamt;
          FN_SRA:  result = $unsigned($signed(rt_value) >>> shamt);
          FN_MULT: begin
            hilo_overwrite  = hilo.unread;
            cmd.mult        = 1'b1;
            cmd.mult_signed = 1'b1;
          end
          FN_MULTU: begin
            hilo_overwrite = hilo.unread;
            cmd.mult       = 1'b1;
          end
          FN_MFHI: begin
            result   = hilo.hi;
            cmd.read = 1'b1;
          end
          FN_MFLO: begin
            result   = hilo.lo;
            cmd.read = 1'b1;
          end
          default: result = last_result;
        endcase
      end else if (is_mem) begin
        result       = sum_ri;
        num_overflow = ovf_add_ri;
      end else if (is_branch) begin
        num_overflow = ovf_pc;
      end else begin
        case (opcode)
          OP_ADDIU: result = sum_ri;
          OP_ANDI:  result = ze & rs_value;
          OP_ORI:   result = ze | rs_value;
          OP_NORI:  result = ~(ze | rs_value);
          OP_SLTI:  result = {{(DataW-1){1'b0}}, $signed(rs_value) < $signed(se)};
          OP_LUI:   result = {imm, {(DataW-ImmW){1'b0}}};
          OP_JAL:   result = link_value;
          default:  result = last_result;
        endcase
      end
    end
  end

endmodule

/* rtl/mexalu_hilo.sv */
// multiplier and hi/lo product registers with the unread flag
module mexalu_hilo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  mexalu_pkg::hilo_cmd_t        cmd,
  input  logic [mexalu_pkg::DataW-1:0] rs_value,
  input  logic [mexalu_pkg::DataW-1:0] rt_value,
  output mexalu_pkg::hilo_state_t      hilo
);
  import mexalu_pkg::*;

  logic signed [DataW:0]     op_a;
  logic signed [DataW:0]     op_b;
  logic signed [2*DataW+1:0] product;
  logic [DataW-1:0]          hi;
  logic [DataW-1:0]          lo;
  logic                      unread;

  // one extra bit carries the sign for mult and a zero for multu
  assign op_a    = {cmd.mult_signed & rs_value[DataW-1], rs_value};
  assign op_b    = {cmd.mult_signed & rt_value[DataW-1], rt_value};
  assign product = op_a * op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      hi     <= '0;
      lo     <= '0;
      unread <= 1'b0;
    end else if (advance) begin
      if (cmd.mult) begin
        hi     <= product[2*DataW-1:DataW];
        lo     <= product[DataW-1:0];
        unread <= 1'b1;
      end else if (cmd.read) begin
        unread <= 1'b0;
      end
    end
  end

  assign hilo.hi     = hi;
  assign hilo.lo     = lo;
  assign hilo.unread = unread;

endmodule

/* rtl/mips_execute_alu.sv */
// top level of the execute-stage alu: input register, alu, result register
// Execute stage of a MIPS-like pipeline. One instruction is taken every clock
// cycle while in_stall is low. Its result passes through the input register and
// then the result register, which holds it until it is taken. All alu work,
// including the 32x32 mult/multu into HI/LO, is done combinationally between
// those registers, so mfhi/mflo right after a multiply see the new product. A
// request is accepted while a finished result still waits at the output as long
// as the input register is free; in_stall only rises when both registers are
// full and out_stall is high. Bubbles, branches, multiplies and unknown codes
// repeat the previous result.
module mips_execute_alu (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         bubble,
  input  logic [mexalu_pkg::OpW-1:0]   opcode,
  input  logic [mexalu_pkg::OpW-1:0]   func,
  input  logic [mexalu_pkg::ShW-1:0]   shamt,
  input  logic [mexalu_pkg::ImmW-1:0]  imm,
  input  logic [mexalu_pkg::DataW-1:0] rs_value,
  input  logic [mexalu_pkg::DataW-1:0] rt_value,
  input  logic [mexalu_pkg::DataW-1:0] pc_value,
  input  logic [mexalu_pkg::DataW-1:0] link_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mexalu_pkg::DataW-1:0] result,
  output logic                         num_overflow,
  output logic                         hilo_overwrite
);
  import mexalu_pkg::*;

  logic             s1_valid;
  logic             s1_bubble;
  logic [OpW-1:0]   s1_opcode;
  logic [OpW-1:0]   s1_func;
  logic [ShW-1:0]   s1_shamt;
  logic [ImmW-1:0]  s1_imm;
  logic [DataW-1:0] s1_rs;
  logic [DataW-1:0] s1_rt;
  logic [DataW-1:0] s1_pc;
  logic [DataW-1:0] s1_link;
  logic [DataW-1:0] last_result;

  logic             out_free;
  logic             advance;
  logic             accept;
  logic [DataW-1:0] alu_result;
  logic             alu_ovf;
  logic             alu_ow;
  hilo_cmd_t        cmd;
  hilo_state_t      hilo;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bubble <= bubble;
      s1_opcode <= opcode;
      s1_func   <= func;
      s1_shamt  <= shamt;
      s1_imm    <= imm;
      s1_rs     <= rs_value;
      s1_rt     <= rt_value;
      s1_pc     <= pc_value;
      s1_link   <= link_value;
    end
  end

  mexalu_alu u_alu (
    .bubble         (s1_bubble),
    .opcode         (s1_opcode),
    .func           (s1_func),
    .shamt          (s1_shamt),
    .imm            (s1_imm),
    .rs_value       (s1_rs),
    .rt_value       (s1_rt),
    .pc_value       (s1_pc),
    .link_value     (s1_link),
    .last_result    (last_result),
    .hilo           (hilo),
    .result         (alu_result),
    .num_overflow   (alu_ovf),
    .hilo_overwrite (alu_ow),
    .cmd            (cmd)
  );

  mexalu_hilo u_hilo (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cmd      (cmd),
    .rs_value (s1_rs),
    .rt_value (s1_rt),
    .hilo     (hilo)
  );

  // bubbles and no-result ops give last_result back, so loading it always is safe
  always_ff @(posedge clk) begin
    if (rst) begin
      last_result <= '0;
    end else if (advance) begin
      last_result <= alu_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result         <= alu_result;
      num_overflow   <= alu_ovf;
      hilo_overwrite <= alu_ow;
    end
  end

  // a multiply never reports arithmetic overflow
  assert property (@(posedge clk) disable iff (rst)
    out_valid && hilo_overwrite |-> !num_overflow)
    else $error("overflow and hilo overwrite flagged together");

  // a multiply leaves the product marked unread
  assert property (@(posedge clk) disable iff (rst)
    advance && cmd.mult |=> hilo.unread)
    else $error("hilo not marked unread after multiply");

  // the input side only stalls when the input register holds a request
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("stall without a full pipeline");

  // nothing appears at the output without a request in flight
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid && !out_valid |=> !out_valid)
    else $error("result without a request");

  // the result register reflects the last result after each step
  assert property (@(posedge clk) disable iff (rst)
    advance |=> result == last_result)
    else $error("last result out of step with output");

endmodule
